>>> sv/csv_field_tokenizer_macros.svh
`ifndef CSV_FIELD_TOKENIZER_MACROS_SVH
`define CSV_FIELD_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CSVTOK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csv_field_tokenizer: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CSVTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csv_field_tokenizer: next-cycle check failed");

`endif

>>> sv/csvtok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csvtok_pkg;

  localparam logic [7:0] QUOTE_CH   = 8'h22;
  localparam logic [7:0] COMMA_CH   = 8'h2C;
  localparam logic [7:0] NEWLINE_CH = 8'h0A;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOI  = 1'b1;

  localparam logic RES_CONTENT  = 1'b0;
  localparam logic RES_BOUNDARY = 1'b1;

  typedef struct packed {
    logic kind;
    logic [7:0] data_byte;
  } csvtok_item_t;

  typedef struct packed {
    logic result_kind;
    logic [7:0] content_byte;
    logic [7:0] column_index;
    logic record_end;
    logic [15:0] record_index;
  } csvtok_result_t;

  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic record_open;
    logic [7:0] current_column;
    logic [15:0] current_record;
  } csvtok_state_t;

endpackage

`default_nettype wire

>>> sv/csvtok_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface csvtok_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface csvtok_out_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic [7:0] content_byte;
  logic [7:0] column_index;
  logic record_end;
  logic [15:0] record_index;

  modport source (
    output valid, output result_kind, output content_byte, output column_index,
    output record_end, output record_index, input ready
  );
  modport sink (
    input valid, input result_kind, input content_byte, input column_index,
    input record_end, input record_index, output ready
  );
endinterface

`default_nettype wire

>>> sv/csv_field_tokenizer.sv
// Channel | Direction | Payload
// in_ch   | sink      | kind, data_byte
// out_ch  | source    | result_kind, content_byte, column_index, record_end, record_index
//
// One item per cycle is sustained while out_ch is ready; an item is registered in the
// input register, and its result, if any, in the output register, which drives out_ch.
// The limit is the update of the tokenizer state, done combinationally between the input
// register and the output register.
// Reset (rst_n low, synchronous) empties both registers and clears the tokenizer state.
// When out_ch is stalled the input register holds one item, then in_ch.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic clk,
  input  logic rst_n,
  csvtok_in_if.sink    in_ch,
  csvtok_out_if.source out_ch
);
  import csvtok_pkg::*;

  localparam int unsigned COL_CAP_INT = (MAX_COLUMNS - 1 > 255) ? 255 : MAX_COLUMNS - 1;
  localparam logic [7:0] COL_CAP = COL_CAP_INT[7:0];

  logic           s1_valid_r;
  csvtok_item_t   s1_item_r;
  csvtok_state_t  state_r;
  csvtok_state_t  state_nxt;
  logic           out_valid_r;
  csvtok_result_t out_res_r;
  logic           step_valid;
  csvtok_result_t step_res;
  logic           s1_adv;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  csvtok_step #(
    .COL_CAP(COL_CAP)
  ) u_step (
    .state_cur(state_r),
    .item(s1_item_r),
    .state_nxt(state_nxt),
    .res_valid(step_valid),
    .res(step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.kind <= in_ch.kind;
      s1_item_r.data_byte <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_adv && step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && step_valid) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_res_r.result_kind;
  assign out_ch.content_byte = out_res_r.content_byte;
  assign out_ch.column_index = out_res_r.column_index;
  assign out_ch.record_end   = out_res_r.record_end;
  assign out_ch.record_index = out_res_r.record_index;

`include "csv_field_tokenizer_macros.svh"

  `CSVTOK_ASSERT_NEXT(a_eoi_clears_state, clk, rst_n, s1_adv && s1_item_r.kind == KIND_EOI, state_r == '0)
  `CSVTOK_ASSERT_NOW(a_pending_needs_quotes, clk, rst_n, state_r.quote_pending, state_r.inside_quotes)
  `CSVTOK_ASSERT_NOW(a_column_capped, clk, rst_n, 1'b1, state_r.current_column <= COL_CAP)
  `CSVTOK_ASSERT_NOW(a_content_not_end, clk, rst_n, out_valid_r && out_res_r.result_kind == RES_CONTENT, !out_res_r.record_end)

endmodule

`default_nettype wire

>>> sv/csvtok_step.sv
`timescale 1ns / 1ps
`default_nettype none

module csvtok_step #(
  parameter logic [7:0] COL_CAP = 8'd255
) (
  input  csvtok_pkg::csvtok_state_t  state_cur,
  input  csvtok_pkg::csvtok_item_t   item,
  output csvtok_pkg::csvtok_state_t  state_nxt,
  output logic                       res_valid,
  output csvtok_pkg::csvtok_result_t res
);
  import csvtok_pkg::*;

  logic in_q;
  logic done;

  always_comb begin
    state_nxt = state_cur;
    res_valid = 1'b0;
    res.result_kind  = RES_CONTENT;
    res.content_byte = 8'd0;
    res.column_index = state_cur.current_column;
    res.record_end   = 1'b0;
    res.record_index = state_cur.current_record;
    in_q = state_cur.inside_quotes;
    done = 1'b0;

    if (item.kind == KIND_EOI) begin
      res_valid = state_cur.record_open;
      res.result_kind = RES_BOUNDARY;
      res.record_end = 1'b1;
      state_nxt = '0;
    end else begin
      state_nxt.record_open = 1'b1;

      // A held quote is resolved by the byte after it.
      if (state_cur.quote_pending) begin
        state_nxt.quote_pending = 1'b0;
        if (item.data_byte == QUOTE_CH) begin
          res_valid = 1'b1;
          res.content_byte = QUOTE_CH;
          done = 1'b1;
        end else begin
          in_q = 1'b0;
        end
      end

      if (!done) begin
        if (item.data_byte == QUOTE_CH) begin
          if (in_q) begin
            state_nxt.quote_pending = 1'b1;
          end else begin
            in_q = 1'b1;
          end
        end else if (!in_q && item.data_byte == COMMA_CH) begin
          res_valid = 1'b1;
          res.result_kind = RES_BOUNDARY;
          if (state_cur.current_column < COL_CAP) begin
            state_nxt.current_column = state_cur.current_column + 8'd1;
          end
        end else if (!in_q && item.data_byte == NEWLINE_CH) begin
          res_valid = 1'b1;
          res.result_kind = RES_BOUNDARY;
          res.record_end = 1'b1;
          state_nxt.current_column = 8'd0;
          state_nxt.current_record = state_cur.current_record + 16'd1;
          state_nxt.record_open = 1'b0;
        end else begin
          res_valid = 1'b1;
          res.content_byte = item.data_byte;
        end
      end

      state_nxt.inside_quotes = in_q;
    end
  end

endmodule

`default_nettype wire

>>> tb/csv_field_tokenizer_tb.sv
`timescale 1ns / 1ps

module csv_field_tokenizer_tb;
  import csvtok_pkg::*;

  localparam int MAX_COLS = 256;
  localparam logic [7:0] COL_CAP = (MAX_COLS - 1 > 255) ? 8'd255 : 8'(MAX_COLS - 1);
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_LIMIT = 10;
  localparam csvtok_result_t NO_RESULT = '0;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_check_t;

  typedef struct packed {
    row_check_t chk;
    csvtok_item_t item;
    csvtok_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  csvtok_in_if in_ch ();
  csvtok_out_if out_ch ();

  csv_field_tokenizer #(
    .MAX_COLUMNS(MAX_COLS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  csvtok_state_t tok_state;
  csvtok_result_t expected_tokens[$];
  csvtok_item_t token_stream[$];
  stim_row_t directed_rows [0:23];

  bit idle_on;
  bit holdoff_req;
  int error_count;
  int items_sent;
  int eoi_sent;
  int results_seen;
  int record_ends_seen;
  int wide_records;
  int quiet_cycles;
  logic [7:0] max_column_seen;

  // Tokenizer state update for one accepted item; returns 1 when a result is produced.
  function automatic bit tokenize_step(input csvtok_item_t it, output csvtok_result_t res);
    res = '0;
    res.column_index = tok_state.current_column;
    res.record_index = tok_state.current_record;
    if (it.kind == KIND_EOI) begin
      res.result_kind = RES_BOUNDARY;
      res.record_end = 1'b1;
      tokenize_step = tok_state.record_open;
      tok_state = '0;
      return tokenize_step;
    end
    tok_state.record_open = 1'b1;
    if (tok_state.quote_pending) begin
      tok_state.quote_pending = 1'b0;
      if (it.data_byte == QUOTE_CH) begin
        res.result_kind = RES_CONTENT;
        res.content_byte = QUOTE_CH;
        return 1'b1;
      end
      tok_state.inside_quotes = 1'b0;
    end
    if (it.data_byte == QUOTE_CH) begin
      if (tok_state.inside_quotes) begin
        tok_state.quote_pending = 1'b1;
      end else begin
        tok_state.inside_quotes = 1'b1;
      end
      return 1'b0;
    end
    if (!tok_state.inside_quotes && it.data_byte == COMMA_CH) begin
      res.result_kind = RES_BOUNDARY;
      if (tok_state.current_column < COL_CAP) begin
        tok_state.current_column = tok_state.current_column + 8'd1;
      end
      return 1'b1;
    end
    if (!tok_state.inside_quotes && it.data_byte == NEWLINE_CH) begin
      res.result_kind = RES_BOUNDARY;
      res.record_end = 1'b1;
      tok_state.current_column = '0;
      tok_state.current_record = tok_state.current_record + 16'd1;
      tok_state.record_open = 1'b0;
      return 1'b1;
    end
    res.result_kind = RES_CONTENT;
    res.content_byte = it.data_byte;
    return 1'b1;
  endfunction

  task automatic send_item(input csvtok_item_t it, input row_check_t chk,
                           input csvtok_result_t typed);
    csvtok_result_t predicted;
    bit has_res;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.data_byte <= it.data_byte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (it.kind == KIND_EOI) begin
      eoi_sent++;
    end
    has_res = tokenize_step(it, predicted);
    case (chk)
      ROW_PREDICT: begin
        if (has_res) begin
          expected_tokens = {expected_tokens, predicted};
        end
      end
      ROW_TYPED: begin
        expected_tokens = {expected_tokens, typed};
      end
      default: begin
      end
    endcase
  endtask

  function automatic void push_item(input logic kind, input logic [7:0] data);
    csvtok_item_t it;
    it.kind = kind;
    it.data_byte = data;
    token_stream = {token_stream, it};
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == QUOTE_CH || b == COMMA_CH || b == NEWLINE_CH);
    return b;
  endfunction

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0: return QUOTE_CH;
      1: return COMMA_CH;
      2: return NEWLINE_CH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A well-formed record of plain, quoted and empty fields with random content.
  function automatic void append_record();
    int nfields;
    int len;
    logic [7:0] b;
    nfields = $urandom_range(1, 6);
    if (wide_records < 2 && $urandom_range(0, 30) == 0) begin
      nfields = $urandom_range(260, 300);
      wide_records++;
    end
    for (int f = 0; f < nfields; f++) begin
      if (f != 0) begin
        push_item(KIND_BYTE, COMMA_CH);
      end
      case ($urandom_range(0, 3))
        0: begin
        end
        1: begin
          len = (nfields > 6) ? 1 : $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            push_item(KIND_BYTE, plain_byte());
          end
        end
        default: begin
          len = (nfields > 6) ? 0 : $urandom_range(0, 6);
          push_item(KIND_BYTE, QUOTE_CH);
          for (int k = 0; k < len; k++) begin
            b = any_byte();
            push_item(KIND_BYTE, b);
            if (b == QUOTE_CH) begin
              push_item(KIND_BYTE, QUOTE_CH);
            end
          end
          push_item(KIND_BYTE, QUOTE_CH);
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0: push_item(KIND_EOI, 8'($urandom_range(0, 255)));
      1: begin
        push_item(KIND_BYTE, NEWLINE_CH);
        push_item(KIND_EOI, 8'($urandom_range(0, 255)));
      end
      default: push_item(KIND_BYTE, NEWLINE_CH);
    endcase
  endfunction

  // Noise and broken records: stray quotes, unterminated quoted fields, random bytes.
  function automatic void append_noise();
    int len;
    len = $urandom_range(1, 10);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        push_item(KIND_EOI, 8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 1) == 0) begin
        push_item(KIND_BYTE, any_byte());
      end else begin
        case ($urandom_range(0, 4))
          0: push_item(KIND_BYTE, QUOTE_CH);
          1: push_item(KIND_BYTE, COMMA_CH);
          2: push_item(KIND_BYTE, NEWLINE_CH);
          3: push_item(KIND_BYTE, 8'h0D);
          default: push_item(KIND_BYTE, 8'h61);
        endcase
      end
    end
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    csvtok_result_t got;
    csvtok_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.result_kind = out_ch.result_kind;
      got.content_byte = out_ch.content_byte;
      got.column_index = out_ch.column_index;
      got.record_end = out_ch.record_end;
      got.record_index = out_ch.record_index;
      results_seen++;
      if (got.result_kind == RES_BOUNDARY && got.record_end) begin
        record_ends_seen++;
      end
      if (got.column_index > max_column_seen) begin
        max_column_seen = got.column_index;
      end
      if (expected_tokens.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: unexpected transfer kind=%0d byte=%02h col=%0d rend=%0d rec=%0d",
                   $realtime, got.result_kind, got.content_byte, got.column_index,
                   got.record_end, got.record_index);
        end
      end else begin
        want = expected_tokens.pop_front();
        if (got.result_kind !== want.result_kind || got.content_byte !== want.content_byte ||
            got.column_index !== want.column_index || got.record_end !== want.record_end ||
            got.record_index !== want.record_index) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch kind %0d/%0d byte %02h/%02h col %0d/%0d rend %0d/%0d rec %0d/%0d",
                     $realtime, want.result_kind, got.result_kind, want.content_byte,
                     got.content_byte, want.column_index, got.column_index, want.record_end,
                     got.record_end, want.record_index, got.record_index);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_tokens.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int total;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_BYTE;
    in_ch.data_byte <= 8'h00;
    rst_n <= 1'b0;
    tok_state = '0;
    idle_on = 1'b1;
    holdoff_req = 1'b0;
    max_column_seen = '0;

    // Directed rows: chk, kind, data, then result kind, byte, column, record end, record.
    directed_rows = '{
      {ROW_SILENT,  KIND_EOI,  8'h00,      NO_RESULT},
      {ROW_TYPED,   KIND_BYTE, 8'h00,      RES_CONTENT,  8'h00, 8'd0, 1'b0, 16'd0},
      {ROW_TYPED,   KIND_BYTE, 8'hFF,      RES_CONTENT,  8'hFF, 8'd0, 1'b0, 16'd0},
      {ROW_TYPED,   KIND_BYTE, 8'h0D,      RES_CONTENT,  8'h0D, 8'd0, 1'b0, 16'd0},
      {ROW_TYPED,   KIND_BYTE, COMMA_CH,   RES_BOUNDARY, 8'h00, 8'd0, 1'b0, 16'd0},
      {ROW_SILENT,  KIND_BYTE, QUOTE_CH,   NO_RESULT},
      {ROW_PREDICT, KIND_BYTE, 8'h61,      NO_RESULT},
      {ROW_PREDICT, KIND_BYTE, COMMA_CH,   NO_RESULT},
      {ROW_PREDICT, KIND_BYTE, NEWLINE_CH, NO_RESULT},
      {ROW_SILENT,  KIND_BYTE, QUOTE_CH,   NO_RESULT},
      {ROW_TYPED,   KIND_BYTE, QUOTE_CH,   RES_CONTENT,  QUOTE_CH, 8'd1, 1'b0, 16'd0},
      {ROW_SILENT,  KIND_BYTE, QUOTE_CH,   NO_RESULT},
      {ROW_PREDICT, KIND_BYTE, COMMA_CH,   NO_RESULT},
      {ROW_PREDICT, KIND_BYTE, 8'h78,      NO_RESULT},
      {ROW_SILENT,  KIND_BYTE, QUOTE_CH,   NO_RESULT},
      {ROW_PREDICT, KIND_BYTE, 8'h79,      NO_RESULT},
      {ROW_SILENT,  KIND_BYTE, QUOTE_CH,   NO_RESULT},
      {ROW_PREDICT, KIND_BYTE, NEWLINE_CH, NO_RESULT},
      {ROW_TYPED,   KIND_BYTE, NEWLINE_CH, RES_BOUNDARY, 8'h00, 8'd0, 1'b1, 16'd1},
      {ROW_SILENT,  KIND_BYTE, QUOTE_CH,   NO_RESULT},
      {ROW_PREDICT, KIND_BYTE, 8'h7A,      NO_RESULT},
      {ROW_TYPED,   KIND_EOI,  8'h00,      RES_BOUNDARY, 8'h00, 8'd0, 1'b1, 16'd2},
      {ROW_TYPED,   KIND_BYTE, 8'h71,      RES_CONTENT,  8'h71, 8'd0, 1'b0, 16'd0},
      {ROW_TYPED,   KIND_EOI,  8'hFF,      RES_BOUNDARY, 8'h00, 8'd0, 1'b1, 16'd0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, directed_rows[r].chk, directed_rows[r].res);
    end

    while (token_stream.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        append_record();
      end else begin
        append_noise();
      end
    end

    // The receiver stalls for a long stretch while items keep coming, so the input backs up.
    holdoff_req = 1'b1;
    total = token_stream.size();
    for (int n = 0; n < total; n++) begin
      if (n >= total - 200) begin
        idle_on = 1'b0;
      end else if (n % 100 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      send_item(token_stream[n], ROW_PREDICT, NO_RESULT);
    end
    in_ch.valid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d end of input, %0d wide records); checked %0d results.",
             items_sent, eoi_sent, wide_records, results_seen);
    $display("Saw %0d record ends and a highest column index of %0d.",
             record_ends_seen, max_column_seen);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/csvtok_pkg.sv
sv/csvtok_if.sv
sv/csvtok_step.sv
sv/csv_field_tokenizer.sv
tb/csv_field_tokenizer_tb.sv
